/* sv/u8d_pkg.sv */
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int unsigned CP_W    = 31;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TDATA_W = 72;
    localparam int unsigned TUSER_W = 3;

    localparam logic [CNT_W-1:0] CNT_CAP = 17'd65536;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NUL   = 2'd1,
        ST_BAD   = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0]  accum;
        logic [LEN_W-1:0] pending;
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] chars;
        logic [CNT_W-1:0] bytes;
        logic             halted;
    } t_state;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] char_bytes;
        logic             char_valid;
        logic             scan_done;
        t_status          stop_status;
        logic [CNT_W-1:0] char_count;
        logic [CNT_W-1:0] stop_offset;
    } t_result;

endpackage

/* sv/u8d_step.sv */
// combinational decode of one byte against the current decoder state
module u8d_step
    import u8d_pkg::*;
(
    input  t_state            i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_end,
    output t_state            o_state,
    output t_result           o_result,
    output logic              o_emit
);

    logic             valid;
    logic             done;
    t_status          status;
    logic [LEN_W-1:0] lead_n;
    logic [CNT_W:0]   byte_sum;

    always_comb begin
        case (i_byte) inside
            [8'hC0:8'hDF]: lead_n = 3'd1;
            [8'hE0:8'hEF]: lead_n = 3'd2;
            [8'hF0:8'hF7]: lead_n = 3'd3;
            [8'hF8:8'hFB]: lead_n = 3'd4;
            [8'hFC:8'hFD]: lead_n = 3'd5;
            default:       lead_n = 3'd0;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_emit   = 1'b0;
        valid    = 1'b0;
        done     = 1'b0;
        status   = ST_OK;
        byte_sum = '0;
        if (i_state.halted) begin
            if (i_end) begin
                o_state = '0;
            end
        end else begin
            if (i_state.pending == '0) begin
                if (i_byte == 8'h00) begin
                    status = ST_NUL;
                end else if (i_byte inside {[8'h01:8'hBF]}) begin
                    valid               = 1'b1;
                    o_result.code_point = {24'd0, i_byte[6:0]};
                    o_result.char_bytes = 3'd1;
                end else if (i_byte inside {[8'hFE:8'hFF]}) begin
                    status = ST_BAD;
                end else begin
                    o_state.accum   = {23'd0, i_byte & (8'h3F >> lead_n)};
                    o_state.pending = lead_n;
                    o_state.length  = lead_n + 3'd1;
                end
            end else begin
                if (i_byte[7:6] != 2'b10) begin
                    status = ST_BAD;
                end else begin
                    o_state.accum   = {i_state.accum[CP_W-7:0], i_byte[5:0]};
                    o_state.pending = i_state.pending - 3'd1;
                    if (i_state.pending == 3'd1) begin
                        valid               = 1'b1;
                        o_result.code_point = {i_state.accum[CP_W-7:0], i_byte[5:0]};
                        o_result.char_bytes = i_state.length;
                    end
                end
            end

            if (valid) begin
                o_state.chars  = (i_state.chars >= CNT_CAP) ? CNT_CAP
                                                            : i_state.chars + 17'd1;
                byte_sum       = {1'b0, i_state.bytes} + {15'd0, o_result.char_bytes};
                o_state.bytes  = (byte_sum > {1'b0, CNT_CAP}) ? CNT_CAP
                                                               : byte_sum[CNT_W-1:0];
                o_state.accum  = '0;
                o_state.length = '0;
            end
            if (status == ST_OK && i_end && o_state.pending != '0) begin
                status = ST_TRUNC;
            end

            done   = (status != ST_OK) || i_end;
            o_emit = valid || done;

            o_result.char_valid  = valid;
            o_result.scan_done   = done;
            o_result.stop_status = status;
            o_result.char_count  = o_state.chars;
            o_result.stop_offset = o_state.bytes;

            if (done) begin
                if (i_end) begin
                    o_state = '0;
                end else begin
                    o_state.halted  = 1'b1;
                    o_state.accum   = '0;
                    o_state.pending = '0;
                    o_state.length  = '0;
                end
            end
        end
    end

endmodule

/* sv/utf8_stream_decoder_top.sv */
// top level of the utf-8 stream decoder: input word register, decode step, result register
//
// bytes of a buffer arrive one word at a time on the s_axis channel; tdata carries the
// byte and tlast marks the final byte of the buffer.
// results leave on m_axis: tdata holds code point, byte length, character count and
// stop offset; tuser holds the character-valid flag and the stop status; tlast is set
// when the scan stops or the buffer ends.
// a word gives a result when a character completes, when the scan stops (nul, bad
// byte, truncated sequence) or on the final byte; bytes after a stop are swallowed
// up to the final byte, which clears the decoder for the next buffer.
// a byte is first taken into the input register, and its result is then loaded into the result
// register, which drives m_axis; while the result register is held, the byte waits in the input register.
// throughput: one byte per cycle while m_axis takes results; the decode step is a
// single pass of shift, mask and 17-bit counter logic.
// a stalled m_axis holds its result; s_axis_tready drops while the input register holds
// a word and the result register is still held, whether or not that word gives a result.
// reset (synchronous, active low) empties both registers and clears the decoder state.
module utf8_stream_decoder_top
    import u8d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // data_byte[7:0]
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // code_point, char_bytes, char_count, stop_offset, zero pad
    output logic [TUSER_W-1:0] m_axis_tuser,   // char_valid, stop_status
    output logic               m_axis_tlast
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    t_state            r_state;
    t_state            n_state;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              n_emit;
    logic              out_free;
    logic              advance;

    u8d_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_state  (n_state),
        .o_result (n_out),
        .o_emit   (n_emit)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.stop_offset, r_out.char_count,
                            r_out.char_bytes, r_out.code_point};
    assign m_axis_tuser  = {r_out.stop_status, r_out.char_valid};
    assign m_axis_tlast  = r_out.scan_done;

    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (r_state.pending == '0 && r_state.accum == '0))
        else $error("halted decoder holds a partial character");

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending <= 3'd5 && (r_state.pending == '0 || r_state.length > r_state.pending))
        else $error("pending byte count out of range");

    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.char_valid) |->
            (r_out.char_bytes != '0 && r_out.stop_status == ST_OK))
        else $error("completed character with no length or with a stop status");

    a_stop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_status != ST_OK) |-> r_out.scan_done)
        else $error("stop status without scan done");

    a_counts_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.chars <= CNT_CAP && r_state.bytes <= CNT_CAP)
        else $error("counter beyond saturation limit");

    a_swallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_state.halted && !r_in_end) |=> $stable(r_state))
        else $error("swallowed word changed the decoder state");

endmodule
